FILE: hdl/kms_pkg.sv
// kms_pkg: word types, hash constants and mixer helpers for kmer_minimizer_select.
// No dependencies; imported by every module of the block.
package kms_pkg;

  localparam int unsigned HASH_W = 64;
  localparam int unsigned HALF_W = 32;
  localparam int unsigned LEN_W  = 6;

  localparam logic [HASH_W-1:0] MIX_MULT    = 64'hCFEE444D8B59A89B;
  localparam logic [HALF_W-1:0] MIX_MULT_LO = MIX_MULT[HALF_W-1:0];
  localparam logic [HALF_W-1:0] MIX_MULT_HI = MIX_MULT[HASH_W-1:HALF_W];
  localparam logic [LEN_W-1:0]  LEN_RESET   = 6'd15;

  typedef struct packed {
    logic [1:0] base;
    logic       last_base;
  } in_word_t;

  typedef struct packed {
    logic [HASH_W-1:0] minimizer;
    logic [HASH_W-1:0] minimizer_hash;
    logic              too_short;
  } out_word_t;

  // front -> back: canonical m-mer of one window
  typedef struct packed {
    logic [HASH_W-1:0] canon;
    logic              win_valid;
    logic              last;
  } mid_word_t;

  // partial products of a 64x64 multiply, low 64 bits only
  typedef struct packed {
    logic [HASH_W-1:0] ll;
    logic [HALF_W-1:0] c1;
    logic [HALF_W-1:0] c2;
  } pp_t;

  function automatic pp_t mix_mul_pp(input logic [HASH_W-1:0] x);
    pp_t p;
    p.ll = {{HALF_W{1'b0}}, x[HALF_W-1:0]} * {{HALF_W{1'b0}}, MIX_MULT_LO};
    p.c1 = x[HALF_W-1:0] * MIX_MULT_HI;
    p.c2 = x[HASH_W-1:HALF_W] * MIX_MULT_LO;
    return p;
  endfunction

  function automatic logic [HASH_W-1:0] mix_pp_sum(input pp_t p);
    logic [HALF_W-1:0] mid_sum;
    mid_sum = p.c1 + p.c2;
    return p.ll + {mid_sum, {HALF_W{1'b0}}};
  endfunction

  function automatic logic [HASH_W-1:0] xs32(input logic [HASH_W-1:0] v);
    return v ^ {{HALF_W{1'b0}}, v[HASH_W-1:HALF_W]};
  endfunction

endpackage

FILE: hdl/kms_front.sv
// kms_front: takes bases, shifts the forward and reverse-complement windows,
// and forms the canonical m-mer of each full window. Depends on kms_pkg.
module kms_front #(
  parameter int unsigned MAX_MINIMIZER_LEN = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [kms_pkg::LEN_W-1:0] cfg_wr_data,
  input  logic                     push,
  output logic                     full,
  input  kms_pkg::in_word_t        in_data,
  output logic                     q_push,
  input  logic                     q_full,
  output kms_pkg::mid_word_t       q_data
);
  import kms_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_MINIMIZER_LEN);

  logic [LEN_W-1:0]  cfg_len_r;
  logic [HASH_W-1:0] fwd_r, fwd_nxt;
  logic [HASH_W-1:0] rev_r, rev_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic              clr_r;
  logic              pend_r, pend_nxt;
  logic              pend_last_r, pend_win_r;
  logic [LEN_W-1:0]  pend_m_r;

  logic [LEN_W-1:0]  m_eff;
  logic [HASH_W-1:0] fwd_base, rev_base;
  logic [LEN_W-1:0]  cnt_base;
  logic              accept;
  logic [HASH_W-1:0] mask, fwd_w, rev_w;
  logic [6:0]        rev_sh;
  logic              need_push;

  always_comb begin
    m_eff = cfg_len_r;
    if (m_eff == '0) m_eff = LEN_W'(1);
    if (m_eff > MAX_LEN) m_eff = MAX_LEN;
  end

  assign full   = pend_r;
  assign accept = push && !pend_r;

  always_comb begin
    fwd_base = clr_r ? '0 : fwd_r;
    rev_base = clr_r ? '0 : rev_r;
    cnt_base = clr_r ? '0 : cnt_r;
    fwd_nxt  = {fwd_base[HASH_W-3:0], in_data.base};
    rev_nxt  = {~in_data.base, rev_base[HASH_W-1:2]};
    cnt_nxt  = (cnt_base < MAX_LEN) ? cnt_base + LEN_W'(1) : cnt_base;
  end

  // window extraction on the registered windows, while the item is pending
  always_comb begin
    for (int i = 0; i < HASH_W / 2; i++) begin
      mask[2*i +: 2] = {2{(LEN_W'(i) < pend_m_r)}};
    end
    rev_sh = 7'd64 - {pend_m_r, 1'b0};
    fwd_w  = fwd_r & mask;
    rev_w  = rev_r >> rev_sh;
  end

  always_comb begin
    q_data.canon     = (rev_w < fwd_w) ? rev_w : fwd_w;
    q_data.win_valid = pend_win_r;
    q_data.last      = pend_last_r;
  end

  assign need_push = pend_win_r || pend_last_r;
  assign q_push    = pend_r && need_push && !q_full;

  always_comb begin
    pend_nxt = pend_r;
    if (pend_r && (!need_push || !q_full)) pend_nxt = 1'b0;
    if (accept) pend_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r <= LEN_RESET;
      cnt_r     <= '0;
      clr_r     <= 1'b1;
      pend_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) cfg_len_r <= cfg_wr_data;
      pend_r <= pend_nxt;
      if (accept) begin
        cnt_r <= cnt_nxt;
        clr_r <= in_data.last_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_r       <= fwd_nxt;
      rev_r       <= rev_nxt;
      pend_last_r <= in_data.last_base;
      pend_win_r  <= (cnt_nxt >= m_eff);
      pend_m_r    <= m_eff;
    end
  end

endmodule

FILE: hdl/kms_queue.sv
// kms_queue: short queue of canonical m-mer words between front and back.
// Depends on kms_pkg for the word type.
module kms_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  kms_pkg::mid_word_t wr_data,
  output logic               full,
  input  logic               rd_en,
  output kms_pkg::mid_word_t rd_data,
  output logic               empty
);
  import kms_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mid_word_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign full    = (count_r == (PTR_W+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count_r <= count_r + (PTR_W+1)'(1);
        2'b01:   count_r <= count_r - (PTR_W+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: hdl/kms_back.sv
// kms_back: pipelined xorshift-multiply hash, running minimum and result register.
// Depends on kms_pkg for word types and mixer helpers.
module kms_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  kms_pkg::mid_word_t  q_data,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output kms_pkg::out_word_t  out_data
);
  import kms_pkg::*;

  logic              s1_v_r, s2_v_r, s3_v_r;
  pp_t               s1_pp_r, s2_pp_r;
  logic [HASH_W-1:0] s1_canon_r, s2_canon_r, s3_canon_r;
  logic              s1_win_r, s2_win_r, s3_win_r;
  logic              s1_last_r, s2_last_r, s3_last_r;
  logic [HASH_W-1:0] s3_h_r;

  logic              have_r;
  logic [HASH_W-1:0] best_hash_r, best_min_r;
  logic              out_v_r, out_v_nxt;
  out_word_t         out_r;

  logic              stall, adv, better, have_nxt, fin;
  logic [HASH_W-1:0] hash_nxt, min_nxt;

  // only a finished k-mer meeting a full result register holds the pipe
  assign stall = s3_v_r && s3_last_r && out_v_r && !pop;
  assign adv   = !stall;
  assign q_pop = adv && !q_empty;
  assign fin   = adv && s3_v_r && s3_last_r;

  always_comb begin
    better   = s3_win_r && (!have_r || (s3_h_r < best_hash_r));
    hash_nxt = better ? s3_h_r : best_hash_r;
    min_nxt  = better ? s3_canon_r : best_min_r;
    have_nxt = have_r || better;
  end

  assign out_v_nxt = (out_v_r && !pop) || fin;
  assign empty     = !out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      have_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      if (adv) begin
        s1_v_r <= !q_empty;
        s2_v_r <= s1_v_r;
        s3_v_r <= s2_v_r;
        if (s3_v_r) have_r <= s3_last_r ? 1'b0 : have_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pp_r    <= mix_mul_pp(xs32(q_data.canon));
      s1_canon_r <= q_data.canon;
      s1_win_r   <= q_data.win_valid;
      s1_last_r  <= q_data.last;

      s2_pp_r    <= mix_mul_pp(xs32(mix_pp_sum(s1_pp_r)));
      s2_canon_r <= s1_canon_r;
      s2_win_r   <= s1_win_r;
      s2_last_r  <= s1_last_r;

      s3_h_r     <= xs32(mix_pp_sum(s2_pp_r));
      s3_canon_r <= s2_canon_r;
      s3_win_r   <= s2_win_r;
      s3_last_r  <= s2_last_r;

      if (s3_v_r) begin
        best_hash_r <= hash_nxt;
        best_min_r  <= min_nxt;
      end
    end
    if (fin) begin
      out_r.minimizer      <= have_nxt ? min_nxt : '0;
      out_r.minimizer_hash <= have_nxt ? hash_nxt : '0;
      out_r.too_short      <= !have_nxt;
    end
  end

endmodule

FILE: hdl/kmer_minimizer_select.sv
// kmer_minimizer_select: canonical k-mer minimizer with xorshift-multiply hash.
// Flow: the front holds one base at a time (window shift, then extract/compare) and takes
// no new base until the last has left the extract step. Path from last base accepted to
// result word: front extract into the queue, three hash stages, result register.
// Reset: synchronous active-low rst_n clears all control state; the length register
// returns to 15. No clearing pass. Depends on kms_pkg, kms_front, kms_queue, kms_back.
module kmer_minimizer_select #(
  parameter int unsigned MAX_MINIMIZER_LEN = 32,
  parameter int unsigned QUEUE_DEPTH       = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [kms_pkg::LEN_W-1:0] cfg_wr_data,
  input  logic                      push,
  output logic                      full,
  input  kms_pkg::in_word_t         in_data,
  output logic                      empty,
  input  logic                      pop,
  output kms_pkg::out_word_t        out_data
);
  import kms_pkg::*;

  logic      q_push, q_full, q_pop, q_empty;
  mid_word_t q_wr_data, q_rd_data;

  kms_front #(
    .MAX_MINIMIZER_LEN(MAX_MINIMIZER_LEN)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .push       (push),
    .full       (full),
    .in_data    (in_data),
    .q_push     (q_push),
    .q_full     (q_full),
    .q_data     (q_wr_data)
  );

  kms_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_push),
    .wr_data(q_wr_data),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_data(q_rd_data),
    .empty  (q_empty)
  );

  kms_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_rd_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data)
  );

  // front holds one base at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    push && !full |=> full)
    else $error("front took a second base before forwarding the first");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_data.too_short |->
      (out_data.minimizer == '0) && (out_data.minimizer_hash == '0))
    else $error("too-short word carries a nonzero minimizer or hash");

  a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full) && !(q_pop && q_empty))
    else $error("queue written when full or read when empty");

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking testbench for kmer_minimizer_select.
// Drives bases through the push/full queue port and checks every popped result word
// against an in-bench minimizer tracker. Depends on kms_pkg and kmer_minimizer_select.
module tb_top;
  import kms_pkg::*;

  localparam int MAX_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_LEN = 32;
  localparam logic [63:0] HASH_K = 64'hCFEE444D8B59A89B;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;
  logic push = 1'b0;
  logic full;
  in_word_t in_data = '0;
  logic empty;
  logic pop = 1'b0;
  out_word_t out_data;

  kmer_minimizer_select u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .push       (push),
    .full       (full),
    .in_data    (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data   (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // tracker state
  logic [LEN_W-1:0] len_reg;
  logic [63:0] fwd_win;
  logic [63:0] rev_win;
  int bases_seen;
  logic [63:0] best_hash;
  logic [63:0] best_mer;
  bit have_best;

  out_word_t pending_minimizers[$];

  int mismatches = 0;
  int results_checked = 0;
  int bases_sent = 0;
  int kmers_sent = 0;
  int length_writes = 0;
  int cycle_cnt = 0;
  bit send_burst = 0;
  bit pop_burst = 0;

  function automatic logic [63:0] mix64(input logic [63:0] v);
    logic [63:0] x;
    x = (v ^ (v >> 32)) * HASH_K;
    x = (x ^ (x >> 32)) * HASH_K;
    return x ^ (x >> 32);
  endfunction

  function automatic int window_bases(input logic [LEN_W-1:0] v);
    int m;
    m = int'(v);
    if (m == 0) m = 1;
    if (m > MAX_LEN) m = MAX_LEN;
    return m;
  endfunction

  // mostly random gaps, with runs of back-to-back words
  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 19) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic clear_kmer_state();
    fwd_win = '0;
    rev_win = '0;
    bases_seen = 0;
    best_hash = '0;
    best_mer = '0;
    have_best = 0;
  endtask

  task automatic track_base(input in_word_t w);
    int m;
    logic [63:0] mask;
    logic [63:0] fw;
    logic [63:0] rv;
    logic [63:0] canon;
    logic [63:0] h;
    out_word_t r;
    m = window_bases(len_reg);
    fwd_win = {fwd_win[61:0], w.base};
    rev_win = {~w.base, rev_win[63:2]};
    if (bases_seen < MAX_LEN) bases_seen++;
    if (bases_seen >= m) begin
      mask = (m >= 32) ? '1 : ((64'd1 << (2 * m)) - 64'd1);
      fw = fwd_win & mask;
      rv = rev_win >> (64 - 2 * m);
      canon = (rv < fw) ? rv : fw;
      h = mix64(canon);
      if (!have_best || h < best_hash) begin
        best_hash = h;
        best_mer = canon;
        have_best = 1;
      end
    end
    if (w.last_base) begin
      if (have_best) begin
        r.minimizer = best_mer;
        r.minimizer_hash = best_hash;
        r.too_short = 1'b0;
      end else begin
        r = '0;
        r.too_short = 1'b1;
      end
      pending_minimizers.push_back(r);
      clear_kmer_state();
      kmers_sent++;
    end
  endtask

  // called at a clock edge; returns at the edge where the word was taken, push still high
  task automatic send_base(input logic [1:0] b, input logic last);
    int gap;
    in_word_t w;
    w.base = b;
    w.last_base = last;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    track_base(w);
    bases_sent++;
  endtask

  task automatic send_kmer(input int len, input logic [1:0] fill, input bit flat);
    for (int i = 0; i < len; i++) begin
      send_base(flat ? fill : 2'($urandom_range(0, 3)), i == len - 1);
    end
  endtask

  // hold the input until every result is out and the pipeline has gone quiet
  task automatic drain();
    push <= 1'b0;
    while (pending_minimizers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_length(input logic [LEN_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    len_reg = v;
    length_writes++;
    cfg_wr_en <= 1'b0;
  endtask

  // result checker
  initial begin
    int gap;
    out_word_t want;
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_gap(pop_burst);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      results_checked++;
      if (pending_minimizers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: min=%h hash=%h short=%b",
                   out_data.minimizer, out_data.minimizer_hash, out_data.too_short);
      end else begin
        want = pending_minimizers.pop_front();
        if (out_data.minimizer !== want.minimizer ||
            out_data.minimizer_hash !== want.minimizer_hash ||
            out_data.too_short !== want.too_short) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch on result %0d:", results_checked);
            $display("  minimizer exp=%h got=%h", want.minimizer, out_data.minimizer);
            $display("  hash      exp=%h got=%h", want.minimizer_hash, out_data.minimizer_hash);
            $display("  too_short exp=%b got=%b", want.too_short, out_data.too_short);
          end
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < MAX_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("kmer_minimizer_select test failed");
    $finish;
  end

  // register at reset value: one k-mer of exactly 15 bases
  task automatic test_default_length();
    send_kmer(15, 2'd0, 0);
    drain();
  endtask

  task automatic test_single_base_windows();
    set_length(6'd1);
    send_base(2'd0, 1'b1);
    send_base(2'd3, 1'b1);
    drain();
  endtask

  // zero length behaves as one
  task automatic test_zero_length();
    set_length(6'd0);
    send_base(2'd2, 1'b0);
    send_base(2'd1, 1'b1);
    drain();
  endtask

  // AT is its own reverse complement: forward code kept on the tie
  task automatic test_palindrome_tie();
    set_length(6'd2);
    send_base(2'd0, 1'b0);
    send_base(2'd3, 1'b1);
    drain();
  endtask

  // 63 clamps to 32; three bases is too short
  task automatic test_over_length_short();
    set_length(6'd63);
    send_base(2'd3, 1'b0);
    send_base(2'd1, 1'b0);
    send_base(2'd2, 1'b1);
    drain();
  endtask

  task automatic test_length_change_mid_kmer();
    set_length(6'd3);
    send_base(2'd1, 1'b0);
    send_base(2'd2, 1'b0);
    drain();
    set_length(6'd2);
    send_base(2'd0, 1'b1);
    drain();
  endtask

  task automatic test_random_phases();
    int lens[14] = '{1, 2, 15, 31, 32, 0, 63, 40, 7, 20, 12, 5, 0, 0};
    int budget;
    int m;
    int klen;
    int sel;
    lens[12] = $urandom_range(0, 63);
    lens[13] = $urandom_range(0, 63);
    foreach (lens[p]) begin
      set_length(6'(lens[p]));
      budget = bases_sent + 90;
      if ($urandom_range(0, 2) == 0) begin
        // leave a k-mer open, retune the length, then finish it below
        for (int i = $urandom_range(1, 20); i > 0; i--)
          send_base(2'($urandom_range(0, 3)), 1'b0);
        drain();
        set_length(6'($urandom_range(0, 63)));
      end
      while (bases_sent < budget) begin
        m = window_bases(len_reg);
        sel = $urandom_range(0, 9);
        if (sel == 0) klen = $urandom_range(1, m);
        else if (sel == 1) klen = $urandom_range(33, 70);
        else if (sel == 2 && m > 1) klen = $urandom_range(1, m - 1);
        else klen = $urandom_range(m, m + 10);
        send_kmer(klen, 2'($urandom_range(0, 3)), $urandom_range(0, 3) == 0);
      end
      drain();
    end
  endtask

  initial begin
    len_reg = LEN_RESET;
    clear_kmer_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_default_length();
    test_single_base_windows();
    test_zero_length();
    test_palindrome_tie();
    test_over_length_short();
    test_length_change_mid_kmer();
    test_random_phases();
    drain();
    repeat (20) @(posedge clk);
    if (pending_minimizers.size() != 0) begin
      mismatches++;
      $display("%0d result words never arrived", pending_minimizers.size());
    end
    $display("sent %0d bases in %0d k-mers under %0d length writes", bases_sent, kmers_sent,
             length_writes);
    $display("checked %0d result words, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("kmer_minimizer_select test passed");
    end else begin
      $display("kmer_minimizer_select test failed");
    end
    $finish;
  end

endmodule
